/* hw/rtl/ate_pkg.sv */
// ate_pkg: field widths, operation and status codes and the cell control word
// for the ordered list engine. No dependencies.

package ate_pkg;

	localparam int OP_W   = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 6;
	localparam int STAT_W = 2;
	localparam int FIDX_W = 5;
	localparam int CNT_W  = 6;

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_SORT   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd5;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	// what every cell does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_SORT   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     odd;   // sort phase parity
	} ate_ctl_t;

endpackage

/* hw/rtl/ate_if.sv */
// ate_if: request and response channel interfaces of the list engine.
// Depends on ate_pkg for field widths.

interface ate_req_if;
	logic                              valid;
	logic                              ready;
	logic [ate_pkg::OP_W-1:0]          operation;
	logic signed [ate_pkg::VAL_W-1:0]  item_value;
	logic [ate_pkg::POS_W-1:0]         position;

	modport source (output valid, operation, item_value, position, input ready);
	modport sink   (input valid, operation, item_value, position, output ready);
endinterface

interface ate_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [ate_pkg::STAT_W-1:0]        status;
	logic signed [ate_pkg::VAL_W-1:0]  read_value;
	logic [ate_pkg::FIDX_W-1:0]        found_index;
	logic [ate_pkg::CNT_W-1:0]         entry_count;

	modport source (output valid, status, read_value, found_index, entry_count,
		input ready);
	modport sink   (input valid, status, read_value, found_index, entry_count,
		output ready);
endinterface

/* hw/rtl/ate_cell.sv */
// ate_cell: one list slot. Holds a value and moves it to or from its
// neighbours for insert, delete and odd-even sort. Depends on ate_pkg.

module ate_cell #(
	parameter int DEPTH = 32,
	parameter int IDX   = 0,
	localparam int CW   = $clog2(DEPTH + 1),
	localparam int CMPW = (CW > ate_pkg::POS_W) ? CW : ate_pkg::POS_W
) (
	input  logic                        clk,
	input  ate_pkg::ate_ctl_t           ctl,
	input  logic [ate_pkg::VAL_W-1:0]   val,
	input  logic [CMPW-1:0]             pos,
	input  logic [CMPW-1:0]             cnt,
	input  logic [ate_pkg::VAL_W-1:0]   left_data,
	input  logic [ate_pkg::VAL_W-1:0]   right_data,
	input  logic                        swap_l,
	output logic [ate_pkg::VAL_W-1:0]   data,
	output logic                        swap_r
);

	localparam logic [CMPW-1:0] MY   = CMPW'(IDX);
	localparam logic [CMPW-1:0] NEXT = CMPW'(IDX + 1);

	logic [ate_pkg::VAL_W-1:0] data_q;
	logic [ate_pkg::VAL_W-1:0] data_d;

	// compare-exchange with the right neighbour on this phase
	assign swap_r = (ctl.op == ate_pkg::CELL_SORT) && (MY[0] == ctl.odd) &&
		(NEXT < cnt) && ($signed(data_q) > $signed(right_data));

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			ate_pkg::CELL_INSERT: begin
				if (MY == pos) begin
					data_d = val;
				end else if ((MY > pos) && (MY <= cnt)) begin
					data_d = left_data;
				end
			end
			ate_pkg::CELL_DELETE: begin
				if ((MY >= pos) && (NEXT < cnt)) begin
					data_d = right_data;
				end
			end
			ate_pkg::CELL_SORT: begin
				if (swap_r) begin
					data_d = right_data;
				end else if (swap_l) begin
					data_d = left_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

/* hw/rtl/array_table_engine_core.sv */
// array_table_engine_core: ordered list of DEPTH signed words held in a chain
// of ate_cell slots; uses ate_pkg and ate_if.
// Every word passes an execute step and a finish step; sort adds one odd-even
// phase per cycle, one per entry; search scans the hit bits one per cycle up to the
// count and stops at the first hit. One word in flight; the next can be taken in the
// cycle after a result is loaded. arst_n clears the count,
// the sequencer and the result valid; slot contents are not reset.

module array_table_engine_core #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ate_req_if.sink     req,
	ate_rsp_if.source   rsp
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > ate_pkg::POS_W) ? CW : ate_pkg::POS_W;
	localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SORT = 5'b00100,
		S_SCAN = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	// control
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   ph_q;      // sort phase
	logic [CW-1:0]   scan_q;    // search position
	logic            out_v_q;

	// captured word
	logic [ate_pkg::OP_W-1:0]   op_q;
	logic [ate_pkg::VAL_W-1:0]  val_q;
	logic [ate_pkg::POS_W-1:0]  pos_q;

	// search hit bits, shifted down one per scan cycle
	logic [DEPTH-1:0] hit_q;
	logic [DEPTH-1:0] hit_d;

	// pending result and output register
	logic [ate_pkg::STAT_W-1:0] res_stat_q;
	logic [ate_pkg::VAL_W-1:0]  res_val_q;
	logic [ate_pkg::FIDX_W-1:0] res_idx_q;
	logic [ate_pkg::STAT_W-1:0] out_stat_q;
	logic [ate_pkg::VAL_W-1:0]  out_val_q;
	logic [ate_pkg::FIDX_W-1:0] out_idx_q;
	logic [ate_pkg::CNT_W-1:0]  out_cnt_q;

	// result of the execute cycle
	logic [ate_pkg::STAT_W-1:0] exec_stat;
	logic [ate_pkg::VAL_W-1:0]  exec_val;

	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] scan_x;
	logic [CMPW-1:0] cell_pos;
	logic            has_room;
	logic            accept;
	logic            load_out;
	logic            sort_run;

	ate_pkg::ate_ctl_t          ctl;
	logic [ate_pkg::VAL_W-1:0]  cell_data [DEPTH];
	logic                       swap      [DEPTH];
	logic [ate_pkg::VAL_W-1:0]  rd_sel;

	assign cnt_x    = CMPW'(cnt_q);
	assign pos_x    = CMPW'(pos_q);
	assign scan_x   = CMPW'(scan_q);
	assign has_room = cnt_x < DEPTH_X;
	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == S_FIN) && (!out_v_q || rsp.ready);
	assign sort_run = (state_q == S_SORT) && (ph_q < cnt_q);

	assign req.ready = (state_q == S_IDLE);

	// ---------------------------------------------------------------
	// cell control: append is an insert at the current count
	// ---------------------------------------------------------------
	always_comb begin
		ctl.op   = ate_pkg::CELL_HOLD;
		ctl.odd  = ph_q[0];
		cell_pos = pos_x;
		if (state_q == S_EXEC) begin
			case (op_q)
				ate_pkg::OP_APPEND: begin
					if (has_room) begin
						ctl.op   = ate_pkg::CELL_INSERT;
						cell_pos = cnt_x;
					end
				end
				ate_pkg::OP_INSERT: begin
					if (has_room && (pos_x <= cnt_x)) begin
						ctl.op = ate_pkg::CELL_INSERT;
					end
				end
				ate_pkg::OP_DELETE: begin
					if (pos_x < cnt_x) begin
						ctl.op = ate_pkg::CELL_DELETE;
					end
				end
				default: begin
					ctl.op = ate_pkg::CELL_HOLD;
				end
			endcase
		end else if (sort_run) begin
			ctl.op = ate_pkg::CELL_SORT;
		end
	end

	// ---------------------------------------------------------------
	// the chain
	// ---------------------------------------------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ate_pkg::VAL_W-1:0] left_w;
		logic [ate_pkg::VAL_W-1:0] right_w;
		logic                      swap_l_w;

		if (i == 0) begin : g_first
			assign left_w   = '0;
			assign swap_l_w = 1'b0;
		end else begin : g_mid
			assign left_w   = cell_data[i-1];
			assign swap_l_w = swap[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end

		ate_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.val        (val_q),
			.pos        (cell_pos),
			.cnt        (cnt_x),
			.left_data  (left_w),
			.right_data (right_w),
			.swap_l     (swap_l_w),
			.data       (cell_data[i]),
			.swap_r     (swap[i])
		);
	end

	// read select and per-slot match; the match only within the valid entries
	always_comb begin
		rd_sel = '0;
		hit_d  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (CMPW'(i) == pos_x) begin
				rd_sel = rd_sel | cell_data[i];
			end
			hit_d[i] = (cell_data[i] == val_q) && (CMPW'(i) < cnt_x);
		end
	end

	// status and value settled in the execute cycle; search starts as not found
	always_comb begin
		exec_stat = ate_pkg::ST_OK;
		exec_val  = '0;
		case (op_q)
			ate_pkg::OP_APPEND: begin
				if (!has_room) begin
					exec_stat = ate_pkg::ST_FULL;
				end
			end
			ate_pkg::OP_READ: begin
				if (pos_x < cnt_x) begin
					exec_val = rd_sel;
				end else begin
					exec_stat = ate_pkg::ST_BADPOS;
				end
			end
			ate_pkg::OP_SEARCH: begin
				exec_stat = ate_pkg::ST_NOTFOUND;
			end
			ate_pkg::OP_INSERT: begin
				// full takes precedence over a bad position
				if (!has_room) begin
					exec_stat = ate_pkg::ST_FULL;
				end else if (pos_x > cnt_x) begin
					exec_stat = ate_pkg::ST_BADPOS;
				end
			end
			ate_pkg::OP_DELETE: begin
				if (pos_x >= cnt_x) begin
					exec_stat = ate_pkg::ST_BADPOS;
				end
			end
			default: begin
				exec_stat = ate_pkg::ST_OK;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// sequencer, count and result valid
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ph_q    <= '0;
			scan_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						ate_pkg::OP_CLEAR: begin
							cnt_q   <= '0;
							state_q <= S_FIN;
						end
						ate_pkg::OP_APPEND: begin
							if (has_room) begin
								cnt_q <= cnt_q + 1'b1;
							end
							state_q <= S_FIN;
						end
						ate_pkg::OP_INSERT: begin
							if (has_room && (pos_x <= cnt_x)) begin
								cnt_q <= cnt_q + 1'b1;
							end
							state_q <= S_FIN;
						end
						ate_pkg::OP_DELETE: begin
							if (pos_x < cnt_x) begin
								cnt_q <= cnt_q - 1'b1;
							end
							state_q <= S_FIN;
						end
						ate_pkg::OP_SORT: begin
							ph_q    <= '0;
							state_q <= S_SORT;
						end
						ate_pkg::OP_SEARCH: begin
							scan_q  <= '0;
							state_q <= S_SCAN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_SORT: begin
					// count phases of odd-even transposition order count entries
					if (sort_run) begin
						ph_q <= ph_q + 1'b1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if ((scan_q == cnt_q) || hit_q[0]) begin
						state_q <= S_FIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// payload: captured word, result and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.operation;
			val_q <= req.item_value;
			pos_q <= req.position;
		end

		if (state_q == S_EXEC) begin
			res_stat_q <= exec_stat;
			res_val_q  <= exec_val;
			res_idx_q  <= '0;
			hit_q      <= hit_d;
		end

		if (state_q == S_SCAN) begin
			hit_q <= hit_q >> 1;
			if (hit_q[0]) begin
				res_stat_q <= ate_pkg::ST_OK;
				res_idx_q  <= scan_x[ate_pkg::FIDX_W-1:0];
			end
		end

		if (load_out) begin
			out_stat_q <= res_stat_q;
			out_val_q  <= res_val_q;
			out_idx_q  <= res_idx_q;
			out_cnt_q  <= cnt_x[ate_pkg::CNT_W-1:0];
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_stat_q;
	assign rsp.read_value  = out_val_q;
	assign rsp.found_index = out_idx_q;
	assign rsp.entry_count = out_cnt_q;

endmodule

/* hw/rtl/ate_chk.sv */
// ate_chk: port-level checks on the list engine's response channel, bound
// to array_table_engine_core. Depends on ate_pkg.

module ate_chk #(
	parameter int DEPTH = 32
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [ate_pkg::STAT_W-1:0]  status,
	input logic [ate_pkg::VAL_W-1:0]   read_value,
	input logic [ate_pkg::FIDX_W-1:0]  found_index,
	input logic [ate_pkg::CNT_W-1:0]   entry_count
);

	// a pending response stays valid until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped before taken");

	// count never exceeds the list size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((DEPTH > 63) || (int'(entry_count) <= DEPTH)))
		else $error("entry count above list size");

	// full is reported only on a full list
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ate_pkg::ST_FULL) && (DEPTH < 64)
		|-> (int'(entry_count) == DEPTH))
		else $error("full status with room left");

	// a value or an index is returned only on success
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((read_value != '0) || (found_index != '0))
		|-> (status == ate_pkg::ST_OK))
		else $error("data returned with error status");

endmodule

bind array_table_engine_core ate_chk #(
	.DEPTH (DEPTH)
) u_ate_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.read_value  (rsp.read_value),
	.found_index (rsp.found_index),
	.entry_count (rsp.entry_count)
);
